// ----- sv/aabb_pkg.sv -----
package aabb_pkg;

    // Input item kinds carried on s_axis_tuser
    typedef enum logic [1:0] {
        CMD_WR_BOX   = 2'd0,
        CMD_WR_XFORM = 2'd1,
        CMD_SET_EN   = 2'd2,
        CMD_RUN      = 2'd3
    } t_cmd;

    localparam int NUM_AXES   = 3;
    localparam int MAX_ROWS   = 16;
    localparam int IN_BYTES_W = 72;
    localparam int OUT_DATA_W = 24;

    // Reset value of a scale entry (one in Q16.16)
    localparam logic signed [31:0] SCALE_RESET = 32'sd65536;
    localparam logic signed [31:0] INT32_MAX_V = 32'sh7fffffff;
    localparam logic signed [31:0] INT32_MIN_V = 32'sh80000000;

    // World box of one slot: lo/hi per axis
    typedef struct packed {
        logic signed [31:0] hi;
        logic signed [31:0] lo;
    } t_span;

    typedef t_span [NUM_AXES-1:0] t_wbox;

endpackage

// ----- sv/aabb_broad_phase_overlap_core.sv -----
// Channel   | Dir | Handshake              | Payload
// s_axis    | in  | tvalid/tready          | tuser: command; tdata: slot,axis,value_a,value_b,en
// m_axis    | out | tvalid/tready          | tdata: row, hit_mask; tlast: last
// cfg       | in  | i_cfg_we (no wait)     | i_cfg_wdata: slots_in_use
//
// Write and enable commands are handled in the idle state. A run transforms each axis of every
// enabled slot (box/transform memory read, multiply, shift/saturate, add) and skips disabled
// slots, then for each enabled row reads every later slot through the world memory read port
// and compares it, then emits one output row (a disabled row goes straight to output with an
// empty mask). Reset is synchronous, active low, and takes effect at once through valid bits.
// Input is taken only between runs; a stalled output holds the sequencer at its output step.
module aabb_broad_phase_overlap_core #(
    parameter int SLOTS     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] slot, [5:4] axis, [37:6] value_a, [69:38] value_b, [70] enable_flag
    input  logic [aabb_pkg::IN_BYTES_W-1:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] row, [19:4] hit_mask
    output logic [aabb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int DEPTH    = SLOTS * aabb_pkg::NUM_AXES;
    localparam int AW       = $clog2(DEPTH);
    localparam int SW       = $clog2(SLOTS);
    localparam int ROWS_MAX = (SLOTS < aabb_pkg::MAX_ROWS) ? SLOTS : aabb_pkg::MAX_ROWS;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_XSEL = 9'b000000010,
        ST_XMUL = 9'b000000100,
        ST_XADJ = 9'b000001000,
        ST_XADD = 9'b000010000,
        ST_PRDI = 9'b000100000,
        ST_PLDI = 9'b001000000,
        ST_SCAN = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    // Input unpacking
    aabb_pkg::t_cmd     w_cmd;
    logic [3:0]         w_slot;
    logic [1:0]         w_axis;
    logic signed [31:0] w_va, w_vb;
    logic               w_en_flag;
    logic               w_acc, w_slot_ok;
    logic [AW-1:0]      w_waddr;

    assign w_cmd     = aabb_pkg::t_cmd'(s_axis_tuser);
    assign w_slot    = s_axis_tdata[3:0];
    assign w_axis    = s_axis_tdata[5:4];
    assign w_va      = s_axis_tdata[37:6];
    assign w_vb      = s_axis_tdata[69:38];
    assign w_en_flag = s_axis_tdata[70];
    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_slot_ok = (32'(w_slot) < SLOTS);
    assign w_waddr   = AW'(32'(w_slot) * 3) + AW'(w_axis);

    // Registers
    t_state             r_state;
    logic [4:0]         r_cfg;
    logic [SLOTS-1:0]   r_en;
    logic [DEPTH-1:0]   r_box_vld, r_xf_vld;
    logic [4:0]         r_i, r_j, r_pj;
    logic [1:0]         r_axis;
    logic               r_pend;
    logic [15:0]        r_mask;
    aabb_pkg::t_wbox    r_wacc, r_ibox;
    logic               r_ovalid, r_olast;
    logic [3:0]         r_orow;
    logic [15:0]        r_omask;

    // Memories and their registered read data
    logic [63:0]        mem_box [DEPTH];
    logic [63:0]        mem_xf  [DEPTH];
    aabb_pkg::t_wbox    mem_world [SLOTS];
    logic [63:0]        r_box_q, r_xf_q;
    logic               r_box_vq, r_xf_vq;
    aabb_pkg::t_wbox    r_wq;

    // Datapath registers
    logic signed [63:0] r_plo, r_phi;
    logic signed [31:0] r_pos, r_lo, r_hi;
    logic               r_sneg;

    // Run size
    logic [4:0]         w_n;
    always_comb begin
        w_n = (r_cfg == 5'd0) ? 5'd1 : r_cfg;
        if (w_n > 5'(ROWS_MAX)) begin
            w_n = 5'(ROWS_MAX);
        end
    end

    logic [AW-1:0] w_xaddr;
    assign w_xaddr = AW'(32'(r_i) * 3) + AW'(r_axis);

    logic w_en_i;
    assign w_en_i = r_en[SW'(r_i)];

    // Saturation helpers
    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'(aabb_pkg::INT32_MAX_V)) begin
            res = aabb_pkg::INT32_MAX_V;
        end else if (v < 64'(aabb_pkg::INT32_MIN_V)) begin
            res = aabb_pkg::INT32_MIN_V;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] res;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            res = s[32] ? aabb_pkg::INT32_MIN_V : aabb_pkg::INT32_MAX_V;
        end else begin
            res = s[31:0];
        end
        return res;
    endfunction

    // Overlap test on all axes, inclusive bounds
    function automatic logic boxes_meet(input aabb_pkg::t_wbox a, input aabb_pkg::t_wbox b);
        logic ok;
        ok = 1'b1;
        for (int ax = 0; ax < aabb_pkg::NUM_AXES; ax++) begin
            if (!(a[ax].lo <= b[ax].hi && a[ax].hi >= b[ax].lo)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    logic signed [63:0] w_slo, w_shi;
    assign w_slo = r_plo >>> FRAC_BITS;
    assign w_shi = r_phi >>> FRAC_BITS;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_omask, r_orow};
    assign m_axis_tlast  = r_olast;

    logic w_out_free;
    assign w_out_free = !r_ovalid || m_axis_tready;

    // Table memories: written by commands, read by the transform sequencer
    always_ff @(posedge i_clk) begin
        if (w_acc && w_slot_ok && w_axis != 2'd3) begin
            if (w_cmd == aabb_pkg::CMD_WR_BOX) begin
                mem_box[w_waddr] <= {w_vb, w_va};
            end
            if (w_cmd == aabb_pkg::CMD_WR_XFORM) begin
                mem_xf[w_waddr] <= {w_vb, w_va};
            end
        end
        if (r_state == ST_XSEL && r_i != w_n && w_en_i) begin
            r_box_q  <= mem_box[w_xaddr];
            r_xf_q   <= mem_xf[w_xaddr];
            r_box_vq <= r_box_vld[w_xaddr];
            r_xf_vq  <= r_xf_vld[w_xaddr];
        end
    end

    // World box memory: written per slot after its third axis
    always_ff @(posedge i_clk) begin
        if (r_state == ST_XADD && r_axis == 2'd2) begin
            mem_world[SW'(r_i)] <= {sat_add(r_hi, r_pos), sat_add(r_lo, r_pos),
                                    r_wacc[1], r_wacc[0]};
        end
        if (r_state == ST_PRDI && r_i != w_n) begin
            r_wq <= mem_world[SW'(r_i)];
        end else if (r_state == ST_SCAN && r_j < w_n) begin
            r_wq <= mem_world[SW'(r_j)];
        end
    end

    // Transform datapath
    always_ff @(posedge i_clk) begin
        logic signed [31:0] mn, mx, sc, ps, lo, hi;
        mn = r_box_vq ? r_box_q[31:0]  : 32'sd0;
        mx = r_box_vq ? r_box_q[63:32] : 32'sd0;
        ps = r_xf_vq  ? r_xf_q[31:0]   : 32'sd0;
        sc = r_xf_vq  ? r_xf_q[63:32]  : aabb_pkg::SCALE_RESET;
        lo = sat64(w_slo);
        hi = sat64(w_shi);
        if (r_state == ST_XMUL) begin
            r_plo  <= 64'(mn) * 64'(sc);
            r_phi  <= 64'(mx) * 64'(sc);
            r_pos  <= ps;
            r_sneg <= sc[31];
        end
        if (r_state == ST_XADJ) begin
            r_lo <= r_sneg ? hi : lo;
            r_hi <= r_sneg ? lo : hi;
        end
        if (r_state == ST_XADD) begin
            r_wacc[r_axis].lo <= sat_add(r_lo, r_pos);
            r_wacc[r_axis].hi <= sat_add(r_hi, r_pos);
        end
        if (r_state == ST_PLDI) begin
            r_ibox <= r_wq;
        end
    end

    // Control: config, valid bits, enables, sequencer, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= 5'd16;
            r_en      <= '0;
            r_box_vld <= '0;
            r_xf_vld  <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_pj      <= '0;
            r_axis    <= '0;
            r_pend    <= 1'b0;
            r_mask    <= '0;
            r_ovalid  <= 1'b0;
            r_olast   <= 1'b0;
            r_orow    <= '0;
            r_omask   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            // output step reloads the register itself
            if (r_ovalid && m_axis_tready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        case (w_cmd)
                            aabb_pkg::CMD_WR_BOX: begin
                                if (w_slot_ok && w_axis != 2'd3) begin
                                    r_box_vld[w_waddr] <= 1'b1;
                                end
                            end
                            aabb_pkg::CMD_WR_XFORM: begin
                                if (w_slot_ok && w_axis != 2'd3) begin
                                    r_xf_vld[w_waddr] <= 1'b1;
                                end
                            end
                            aabb_pkg::CMD_SET_EN: begin
                                if (w_slot_ok) begin
                                    r_en[SW'(w_slot)] <= w_en_flag;
                                end
                            end
                            default: begin
                                r_i     <= '0;
                                r_axis  <= '0;
                                r_state <= ST_XSEL;
                            end
                        endcase
                    end
                end
                // pick next enabled slot, or move to the pair scan
                ST_XSEL: begin
                    if (r_i == w_n) begin
                        r_i     <= '0;
                        r_state <= ST_PRDI;
                    end else if (!w_en_i) begin
                        r_i <= r_i + 5'd1;
                    end else begin
                        r_state <= ST_XMUL;
                    end
                end
                ST_XMUL: r_state <= ST_XADJ;
                ST_XADJ: r_state <= ST_XADD;
                ST_XADD: begin
                    if (r_axis == 2'd2) begin
                        r_axis <= '0;
                        r_i    <= r_i + 5'd1;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                    r_state <= ST_XSEL;
                end
                // start a row
                ST_PRDI: begin
                    r_mask <= '0;
                    if (w_en_i) begin
                        r_state <= ST_PLDI;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_PLDI: begin
                    r_j     <= r_i + 5'd1;
                    r_pend  <= 1'b0;
                    r_state <= ST_SCAN;
                end
                // one later slot per cycle; the compare uses the registered world read
                ST_SCAN: begin
                    if (r_j < w_n) begin
                        r_pj   <= r_j;
                        r_j    <= r_j + 5'd1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && r_en[SW'(r_pj)] && boxes_meet(r_ibox, r_wq)) begin
                        r_mask[r_pj[3:0]] <= 1'b1;
                    end
                    if (r_j >= w_n && !r_pend) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_orow   <= r_i[3:0];
                        r_omask  <= r_mask;
                        r_olast  <= (r_i == w_n - 5'd1);
                        if (r_i == w_n - 5'd1) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_i     <= r_i + 5'd1;
                            r_state <= ST_PRDI;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- dv/aabb_overlap_checker.sv -----
`timescale 1ns / 100ps

module aabb_overlap_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [aabb_pkg::IN_BYTES_W-1:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [aabb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_rows_pending,
    output int          o_rows_seen
);

    typedef struct packed {
        logic [3:0]  row;
        logic [15:0] hit_mask;
        logic        last;
    } t_row;

    localparam int SLOTS = 16;

    // shadow table
    logic signed [31:0] box_min [SLOTS*3];
    logic signed [31:0] box_max [SLOTS*3];
    logic signed [31:0] xf_pos  [SLOTS*3];
    logic signed [31:0] xf_scale[SLOTS*3];
    logic               slot_on [SLOTS];
    logic [4:0]         rows_cfg;
    logic signed [31:0] w_lo    [SLOTS*3];
    logic signed [31:0] w_hi    [SLOTS*3];
    t_row               row_queue[$];

    assign o_rows_pending = row_queue.size();

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return aabb_pkg::INT32_MAX_V;
        if (v < -64'sd2147483648) return aabb_pkg::INT32_MIN_V;
        return v[31:0];
    endfunction

    // arithmetic shift floors toward minus infinity
    function automatic logic signed [31:0] scale_mul(input logic signed [31:0] a,
                                                     input logic signed [31:0] s);
        logic signed [63:0] p;
        p = 64'(a) * 64'(s);
        return clamp32(p >>> 16);
    endfunction

    task automatic world_box(input int k);
        logic signed [31:0] lo, hi, t;
        lo = scale_mul(box_min[k], xf_scale[k]);
        hi = scale_mul(box_max[k], xf_scale[k]);
        if (xf_scale[k] < 0) begin
            t = lo; lo = hi; hi = t;
        end
        w_lo[k] = clamp32(64'(lo) + 64'(xf_pos[k]));
        w_hi[k] = clamp32(64'(hi) + 64'(xf_pos[k]));
    endtask

    task automatic predict_overlaps();
        int n;
        logic hit;
        t_row r;
        n = (rows_cfg == 0) ? 1 : (rows_cfg > 16 ? 16 : int'(rows_cfg));
        for (int i = 0; i < n; i++)
            if (slot_on[i])
                for (int a = 0; a < 3; a++) world_box(i*3 + a);
        for (int i = 0; i < n; i++) begin
            r.row = i[3:0];
            r.hit_mask = '0;
            r.last = (i == n - 1);
            if (slot_on[i])
                for (int j = i + 1; j < n; j++) begin
                    hit = slot_on[j];
                    for (int a = 0; a < 3; a++)
                        if (!(w_lo[i*3+a] <= w_hi[j*3+a] && w_hi[i*3+a] >= w_lo[j*3+a]))
                            hit = 0;
                    r.hit_mask[j] = hit;
                end
            row_queue.insert(row_queue.size(), r);
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_rows_seen = 0;
    end

    always @(posedge i_clk) begin
        aabb_pkg::t_cmd cmd;
        int k;
        t_row got, want;
        if (!i_rst_n) begin
            rows_cfg <= 5'd16;
            for (int q = 0; q < SLOTS*3; q++) begin
                box_min[q] = '0; box_max[q] = '0; xf_pos[q] = '0;
                xf_scale[q] = aabb_pkg::SCALE_RESET; w_lo[q] = '0; w_hi[q] = '0;
            end
            for (int q = 0; q < SLOTS; q++) slot_on[q] = 1'b0;
        end else begin
            if (i_cfg_we) rows_cfg <= i_cfg_wdata;
            // command transfer
            if (s_axis_tvalid && s_axis_tready) begin
                cmd = aabb_pkg::t_cmd'(s_axis_tuser);
                k = s_axis_tdata[3:0] * 3 + s_axis_tdata[5:4];
                case (cmd)
                    aabb_pkg::CMD_SET_EN: slot_on[s_axis_tdata[3:0]] = s_axis_tdata[70];
                    aabb_pkg::CMD_WR_BOX: if (s_axis_tdata[5:4] != 2'd3) begin
                        box_min[k] = s_axis_tdata[37:6];
                        box_max[k] = s_axis_tdata[69:38];
                    end
                    aabb_pkg::CMD_WR_XFORM: if (s_axis_tdata[5:4] != 2'd3) begin
                        xf_pos[k]   = s_axis_tdata[37:6];
                        xf_scale[k] = s_axis_tdata[69:38];
                    end
                    default: predict_overlaps();
                endcase
            end
            // result transfer
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tlast};
                o_rows_seen++;
                if (row_queue.size() == 0) begin
                    report("unexpected row", got, 0);
                end else begin
                    want = row_queue.pop_front();
                    if (got.row != want.row) report("row", got.row, want.row);
                    if (got.hit_mask != want.hit_mask)
                        report("hit_mask", got.hit_mask, want.hit_mask);
                    if (got.last != want.last) report("last", got.last, want.last);
                end
            end
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [aabb_pkg::IN_BYTES_W-1:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [aabb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count, rows_pending, rows_seen;
    int          runs_sent;

    aabb_broad_phase_overlap_core dut (.*);

    aabb_overlap_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .o_fail_count(fail_count), .o_rows_pending(rows_pending), .o_rows_seen(rows_seen)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // one command transfer, random gap first
    task automatic send_cmd(input aabb_pkg::t_cmd cmd, input logic [3:0] slot,
                            input logic [1:0] axis, input logic [31:0] va,
                            input logic [31:0] vb, input logic en);
        repeat ($urandom_range(0, 8)) @(negedge i_clk);
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, en, vb, va, axis, slot};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        if (cmd == aabb_pkg::CMD_RUN) runs_sent++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (rows_pending != 0);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_rows(input logic [4:0] v);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(0, 1200)) - 600) <<< 10;
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hffff0000;
            default: return 32'($signed($urandom_range(0, 8)) - 3) <<< 15;
        endcase
    endfunction

    // receiver holds ready low for a random gap, possibly none, before taking each row
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = aabb_pkg::CMD_WR_BOX;
        runs_sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: run on reset table, then extremes, inverted box, zero scale
        send_cmd(aabb_pkg::CMD_RUN, 0, 0, 0, 0, 0);
        for (int s = 0; s < 4; s++) send_cmd(aabb_pkg::CMD_SET_EN, s[3:0], 0, 0, 0, 1);
        send_cmd(aabb_pkg::CMD_WR_BOX, 0, 0, aabb_pkg::INT32_MIN_V, aabb_pkg::INT32_MAX_V, 0);
        send_cmd(aabb_pkg::CMD_WR_XFORM, 0, 0, aabb_pkg::INT32_MAX_V, 32'h7fffffff, 0);
        send_cmd(aabb_pkg::CMD_WR_BOX, 1, 1, 32'h00050000, 32'hfffb0000, 0);
        send_cmd(aabb_pkg::CMD_WR_XFORM, 1, 2, 32'h00010000, 32'd0, 0);
        send_cmd(aabb_pkg::CMD_WR_XFORM, 2, 0, aabb_pkg::INT32_MIN_V,
                 aabb_pkg::INT32_MIN_V, 0);
        send_cmd(aabb_pkg::CMD_WR_BOX, 2, 3, 32'hffffffff, 32'hffffffff, 0);
        send_cmd(aabb_pkg::CMD_WR_BOX, 15, 2, 32'hffff8000, 32'h00008000, 1);
        send_cmd(aabb_pkg::CMD_WR_XFORM, 3, 1, 32'h00000001, 32'hffff0000, 0);
        send_cmd(aabb_pkg::CMD_SET_EN, 15, 0, 0, 0, 1);
        send_cmd(aabb_pkg::CMD_RUN, 0, 0, 0, 0, 0);
        send_cmd(aabb_pkg::CMD_SET_EN, 2, 0, 0, 0, 0);
        send_cmd(aabb_pkg::CMD_RUN, 15, 3, 32'hffffffff, 32'hffffffff, 1);
        wait_drained();
        write_rows(5'd0);
        send_cmd(aabb_pkg::CMD_RUN, 0, 0, 0, 0, 0);
        wait_drained();
        write_rows(5'd31);
        send_cmd(aabb_pkg::CMD_RUN, 0, 0, 0, 0, 0);
        wait_drained();

        // random phases: mostly box/transform writes on few slots, then a run
        for (int ph = 0; ph < 4; ph++) begin
            write_rows(ph == 0 ? 5'd1 : ph == 1 ? 5'd16 : 5'($urandom_range(0, 31)));
            for (int it = 0; it < 22; it++) begin
                int c;
                logic [3:0] sl;
                c = $urandom_range(0, 9);
                sl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
                if (c < 4)
                    send_cmd(aabb_pkg::CMD_WR_BOX, sl, 2'($urandom), rand_q(), rand_q(),
                             1'($urandom));
                else if (c < 7)
                    send_cmd(aabb_pkg::CMD_WR_XFORM, sl, 2'($urandom), rand_q(),
                             rand_scale(), 1'($urandom));
                else if (c < 9)
                    send_cmd(aabb_pkg::CMD_SET_EN, sl, 2'($urandom), $urandom, $urandom,
                             $urandom_range(0, 3) != 0);
                else
                    send_cmd(aabb_pkg::CMD_RUN, sl, 2'($urandom), $urandom, $urandom,
                             1'($urandom));
                if (ph == 2 && it == 10) wait_drained();
            end
            send_cmd(aabb_pkg::CMD_RUN, 0, 0, 0, 0, 0);
            wait_drained();
        end

        $display("Covered %0d runs and %0d result rows over several row-count settings.",
                 runs_sent, rows_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
